FILE: sv/bmsr_pkg.sv
// shared types, codes and tables for the bms reply frame receiver
// no dependencies
`timescale 1ns / 1ps

package bmsr_pkg;

    localparam int MAX_CELLS_DEF   = 32;
    localparam int MAX_SENSORS_DEF = 4;
    localparam int CELL_W          = 6;
    localparam int FADDR_W         = 7;

    localparam logic [7:0] START_BYTE  = 8'hdd;
    localparam logic [7:0] FOOTER_BYTE = 8'h77;
    localparam logic [7:0] CMD_STATUS  = 8'h03;
    localparam logic [7:0] CMD_CELL    = 8'h04;
    localparam logic [7:0] CMD_MAX     = 8'h29;

    localparam logic [CELL_W-1:0] CELLS_RESET = 6'd16;

    localparam logic [1:0] FT_STATUS = 2'd0;
    localparam logic [1:0] FT_CELL   = 2'd1;
    localparam logic [1:0] FT_PARAM  = 2'd2;
    localparam logic [1:0] FT_ERROR  = 2'd3;

    localparam logic [3:0] FID_CURRENT = 4'd1;
    localparam logic [3:0] FID_PERCENT = 4'd6;
    localparam logic [3:0] FID_CELLS   = 4'd7;
    localparam logic [3:0] FID_SENSORS = 4'd8;
    localparam logic [3:0] FID_DELTA   = 4'd4;

    localparam logic [15:0] RECIP_TEN = 16'd52429;

    typedef enum logic [2:0] {
        P_IDLE   = 3'd0,
        P_HEAD   = 3'd1,
        P_PARAM  = 3'd2,
        P_STATUS = 3'd3,
        P_CELL   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        M_STAT  = 2'd0,
        M_CELL  = 2'd1,
        M_PARAM = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        W_IDLE,
        W_SUM_RD,
        W_SUM_ACC,
        W_CHECK,
        W_FETCH_HI,
        W_FETCH_LO,
        W_FETCH_GOT,
        W_CELL_EMIT,
        W_DIV,
        W_PARAM_EMIT,
        W_WAIT
    } walk_state_t;

    typedef struct packed {
        logic               start;
        logic [FADDR_W-1:0] len;
    } walk_req_t;

    typedef struct packed {
        logic              wr;
        logic [CELL_W-1:0] cells;
    } cells_upd_t;

    function automatic logic [FADDR_W-1:0] stat_addr(input logic [3:0] fid);
        logic [FADDR_W-1:0] a;
        case (fid)
            4'd0:    a = 7'd4;
            4'd1:    a = 7'd6;
            4'd2:    a = 7'd8;
            4'd3:    a = 7'd10;
            4'd4:    a = 7'd12;
            4'd5:    a = 7'd20;
            4'd6:    a = 7'd23;
            4'd7:    a = 7'd25;
            4'd8:    a = 7'd26;
            4'd9:    a = 7'd27;
            4'd10:   a = 7'd29;
            4'd11:   a = 7'd31;
            default: a = 7'd33;
        endcase
        return a;
    endfunction

    function automatic logic is_param(input logic [7:0] cmd);
        logic r;
        case (cmd)
            8'h19, 8'h1b, 8'h1d, 8'h1f, 8'h20, 8'h21,
            8'h23, 8'h25, 8'h27, 8'h28, 8'h29: r = 1'b1;
            default:                           r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_temp(input logic [7:0] cmd);
        logic r;
        case (cmd)
            8'h19, 8'h1b, 8'h1d, 8'h1f: r = 1'b1;
            default:                    r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/bmsr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bmsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 72
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/bmsr_frame_walk.sv
// frame-end sequencer: walks the stored frame, checks the sum, emits words
// depends on bmsr_pkg
`timescale 1ns / 1ps

module bmsr_frame_walk
    import bmsr_pkg::*;
#(
    parameter int MAX_CELLS   = MAX_CELLS_DEF,
    parameter int MAX_SENSORS = MAX_SENSORS_DEF,
    parameter int DEPTH       = 72
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  walk_req_t                req,
    output logic                     busy,
    output cells_upd_t               cells_upd,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [7:0]               rd_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               frame_type,
    output logic [7:0]               command_code,
    output logic [3:0]               field_id,
    output logic signed [16:0]       field_value,
    output logic                     last_word
);

    localparam int AW = $clog2(DEPTH);

    walk_state_t st_reg, st_next;
    mode_t mode_reg, mode_next;
    logic [AW-1:0] len_reg, len_next, a_reg, a_next;
    logic [15:0] sum_reg, sum_next, recv_reg, recv_next, word_reg, word_next;
    logic [15:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CELL_W-1:0] lo_i_reg, lo_i_next, hi_i_reg, hi_i_next, ci_reg, ci_next;
    logic [7:0] cmd_reg, cmd_next, hb_reg, hb_next, sens_reg, sens_next;
    logic [3:0] fid_reg, fid_next;
    logic [31:0] prod_reg, prod_next;
    logic ov_reg, ov_next, last_reg, last_next;
    logic [1:0] ft_reg, ft_next;
    logic [3:0] id_reg, id_next;
    logic signed [16:0] val_reg, val_next;

    logic [AW-1:0] ncell_w;
    logic [CELL_W-1:0] ncell;
    logic [15:0] word;
    logic [7:0] smin_hb, smin_reg, cells_sat;
    logic [12:0] quot;

    assign ncell_w  = AW'(len_reg - AW'(7)) >> 1;
    assign ncell    = ncell_w[CELL_W-1:0];
    assign word     = {hb_reg, rd_data};
    assign smin_hb  = (hb_reg > 8'(MAX_SENSORS)) ? 8'(MAX_SENSORS) : hb_reg;
    assign smin_reg = (sens_reg > 8'(MAX_SENSORS)) ? 8'(MAX_SENSORS) : sens_reg;
    assign cells_sat = (hb_reg > 8'(MAX_CELLS)) ? 8'(MAX_CELLS) : hb_reg;
    assign quot     = prod_reg[31:19];

    assign busy         = (st_reg != W_IDLE);
    assign out_valid    = ov_reg;
    assign frame_type   = ft_reg;
    assign command_code = cmd_reg;
    assign field_id     = id_reg;
    assign field_value  = val_reg;
    assign last_word    = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= W_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        len_reg  <= len_next;
        a_reg    <= a_next;
        sum_reg  <= sum_next;
        recv_reg <= recv_next;
        word_reg <= word_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        lo_i_reg <= lo_i_next;
        hi_i_reg <= hi_i_next;
        ci_reg   <= ci_next;
        cmd_reg  <= cmd_next;
        hb_reg   <= hb_next;
        sens_reg <= sens_next;
        fid_reg  <= fid_next;
        prod_reg <= prod_next;
        last_reg <= last_next;
        ft_reg   <= ft_next;
        id_reg   <= id_next;
        val_reg  <= val_next;
    end

    always_comb
    begin
        st_next   = st_reg;
        mode_next = mode_reg;
        len_next  = len_reg;
        a_next    = a_reg;
        sum_next  = sum_reg;
        recv_next = recv_reg;
        word_next = word_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        lo_i_next = lo_i_reg;
        hi_i_next = hi_i_reg;
        ci_next   = ci_reg;
        cmd_next  = cmd_reg;
        hb_next   = hb_reg;
        sens_next = sens_reg;
        fid_next  = fid_reg;
        prod_next = prod_reg;
        ov_next   = ov_reg;
        last_next = last_reg;
        ft_next   = ft_reg;
        id_next   = id_reg;
        val_next  = val_reg;
        rd_addr   = a_reg;
        cells_upd = '{wr: 1'b0, cells: cells_sat[CELL_W-1:0]};

        unique case (st_reg)
            W_IDLE:
            begin
                if (req.start)
                begin
                    len_next = req.len;
                    a_next   = AW'(1);
                    sum_next = 16'd0;
                    st_next  = W_SUM_RD;
                end
            end
            W_SUM_RD:
            begin
                st_next = W_SUM_ACC;
            end
            W_SUM_ACC:
            begin
                if (a_reg == AW'(1))
                    cmd_next = rd_data;
                else if (a_reg <= len_reg - AW'(4))
                    sum_next = sum_reg + {8'd0, rd_data};
                else if (a_reg == len_reg - AW'(3))
                    recv_next[15:8] = rd_data;
                else
                    recv_next[7:0] = rd_data;
                if (a_reg == len_reg - AW'(2))
                    st_next = W_CHECK;
                else
                begin
                    a_next  = a_reg + AW'(1);
                    st_next = W_SUM_RD;
                end
            end
            W_CHECK:
            begin
                lo_next   = 16'd0;
                hi_next   = 16'd0;
                lo_i_next = '0;
                hi_i_next = '0;
                ci_next   = '0;
                fid_next  = 4'd0;
                a_next    = AW'(4);
                if (16'(16'd0 - sum_reg) != recv_reg)
                begin
                    ov_next   = 1'b1;
                    ft_next   = FT_ERROR;
                    id_next   = 4'd0;
                    val_next  = {1'b0, recv_reg};
                    last_next = 1'b1;
                    st_next   = W_WAIT;
                end
                else if (cmd_reg == CMD_STATUS)
                begin
                    mode_next = M_STAT;
                    st_next   = W_FETCH_HI;
                end
                else if (cmd_reg == CMD_CELL)
                begin
                    mode_next = M_CELL;
                    st_next   = (ncell == '0) ? W_CELL_EMIT : W_FETCH_HI;
                end
                else if (is_param(cmd_reg))
                begin
                    mode_next = M_PARAM;
                    st_next   = W_FETCH_HI;
                end
                else
                    st_next = W_IDLE;
            end
            W_FETCH_HI:
            begin
                st_next = W_FETCH_LO;
            end
            W_FETCH_LO:
            begin
                rd_addr = a_reg + AW'(1);
                hb_next = rd_data;
                st_next = W_FETCH_GOT;
            end
            W_FETCH_GOT:
            begin
                unique case (mode_reg)
                    M_STAT:
                    begin
                        ov_next   = 1'b1;
                        ft_next   = FT_STATUS;
                        id_next   = fid_reg;
                        val_next  = {1'b0, word};
                        last_next = 1'b0;
                        st_next   = W_WAIT;
                        case (fid_reg)
                            FID_CURRENT: val_next = {word[15], word};
                            FID_PERCENT: val_next = {9'd0, hb_reg};
                            FID_CELLS:
                            begin
                                val_next     = {9'd0, cells_sat};
                                cells_upd.wr = 1'b1;
                            end
                            FID_SENSORS:
                            begin
                                val_next  = {9'd0, hb_reg};
                                sens_next = hb_reg;
                                last_next = (smin_hb == 8'd0);
                            end
                            default:
                            begin
                                if (fid_reg > FID_SENSORS)
                                    last_next = ({4'd0, fid_reg - FID_SENSORS} == smin_reg);
                            end
                        endcase
                    end
                    M_CELL:
                    begin
                        if (ci_reg == '0 || word < lo_reg)
                        begin
                            lo_next   = word;
                            lo_i_next = ci_reg + CELL_W'(1);
                        end
                        if (ci_reg == '0 || word > hi_reg)
                        begin
                            hi_next   = word;
                            hi_i_next = ci_reg + CELL_W'(1);
                        end
                        ci_next = ci_reg + CELL_W'(1);
                        if (ci_reg + CELL_W'(1) == ncell)
                            st_next = W_CELL_EMIT;
                        else
                        begin
                            a_next  = a_reg + AW'(2);
                            st_next = W_FETCH_HI;
                        end
                    end
                    default:
                    begin
                        word_next = word;
                        st_next   = W_DIV;
                    end
                endcase
            end
            W_CELL_EMIT:
            begin
                ov_next   = 1'b1;
                ft_next   = FT_CELL;
                id_next   = fid_reg;
                last_next = (fid_reg == FID_DELTA);
                case (fid_reg)
                    4'd0:    val_next = {1'b0, lo_reg};
                    4'd1:    val_next = {11'd0, lo_i_reg};
                    4'd2:    val_next = {1'b0, hi_reg};
                    4'd3:    val_next = {11'd0, hi_i_reg};
                    default: val_next = {1'b0, 16'(hi_reg - lo_reg)};
                endcase
                st_next = W_WAIT;
            end
            W_DIV:
            begin
                prod_next = word_reg * RECIP_TEN;
                st_next   = W_PARAM_EMIT;
            end
            W_PARAM_EMIT:
            begin
                ov_next   = 1'b1;
                ft_next   = FT_PARAM;
                id_next   = 4'd0;
                last_next = 1'b1;
                if (!is_temp(cmd_reg))
                    val_next = {1'b0, word_reg};
                else if (quot >= 13'd274)
                    val_next = {4'd0, quot} - 17'sd274;
                else
                    val_next = {4'd0, quot} - 17'sd273;
                st_next = W_WAIT;
            end
            W_WAIT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    if (last_reg)
                        st_next = W_IDLE;
                    else
                    begin
                        fid_next = fid_reg + 4'd1;
                        if (mode_reg == M_STAT)
                        begin
                            a_next  = AW'(stat_addr(fid_reg + 4'd1));
                            st_next = W_FETCH_HI;
                        end
                        else
                            st_next = W_CELL_EMIT;
                    end
                end
            end
            default:
            begin
                st_next = W_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/bms_reply_frame_receiver.sv
// bms reply frame receiver: one byte per accepted word, frame end emits a run of words
// the footer byte starts a walk that reads the stored frame for the checksum, then fetches
// each status word or cell reading and emits the result words under the output handshake
// throughput: one byte per cycle except during the walk, while the walk's busy holds in_stall
// reset: phase idle, byte count 0, expected cells 16; frame store is not cleared
// depends on bmsr_pkg, bmsr_ram, bmsr_frame_walk
`timescale 1ns / 1ps

module bms_reply_frame_receiver
    import bmsr_pkg::*;
#(
    parameter int MAX_CELLS   = MAX_CELLS_DEF,
    parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         frame_type,
    output logic [7:0]         command_code,
    output logic [3:0]         field_id,
    output logic signed [16:0] field_value,
    output logic               last_word
);

    localparam int DEPTH = ((2 * MAX_CELLS + 7) > 72) ? (2 * MAX_CELLS + 7) : 72;
    localparam int AW    = $clog2(DEPTH);

    phase_t phase_reg, phase_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [CELL_W-1:0] cells_reg, cells_next;
    logic [AW-1:0] last_pos, rd_addr;
    logic [7:0] rd_data;
    logic acc, we, busy;
    walk_req_t req;
    cells_upd_t cells_upd;

    assign acc      = in_valid && !in_stall;
    assign in_stall = busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            cells_reg <= CELLS_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            cells_reg <= cells_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cells_next = cells_upd.wr ? cells_upd.cells : cells_reg;
        we         = 1'b0;
        req        = '{start: 1'b0, len: FADDR_W'(cnt_reg + AW'(1))};
        unique case (phase_reg)
            P_PARAM:  last_pos = AW'(8);
            P_STATUS: last_pos = AW'(42);
            P_CELL:   last_pos = AW'({cells_reg, 1'b0}) + AW'(6);
            default:  last_pos = '0;
        endcase
        if (acc)
        begin
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        we         = 1'b1;
                        cnt_next   = AW'(1);
                        phase_next = P_HEAD;
                    end
                end
                P_HEAD:
                begin
                    if (rx_byte >= CMD_STATUS && rx_byte <= CMD_MAX)
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + AW'(1);
                        if (rx_byte == CMD_STATUS)
                            phase_next = P_STATUS;
                        else if (rx_byte == CMD_CELL)
                            phase_next = P_CELL;
                        else
                            phase_next = P_PARAM;
                    end
                    else
                    begin
                        phase_next = P_IDLE;
                        cnt_next   = '0;
                    end
                end
                P_PARAM, P_STATUS, P_CELL:
                begin
                    if (cnt_reg > last_pos)
                    begin
                        phase_next = P_IDLE;
                        cnt_next   = '0;
                    end
                    else if (rx_byte == FOOTER_BYTE && cnt_reg == last_pos)
                    begin
                        we         = 1'b1;
                        req.start  = 1'b1;
                        phase_next = P_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    bmsr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (cnt_reg),
        .wdata (rx_byte),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    bmsr_frame_walk #(
        .MAX_CELLS   (MAX_CELLS),
        .MAX_SENSORS (MAX_SENSORS),
        .DEPTH       (DEPTH)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .busy         (busy),
        .cells_upd    (cells_upd),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_type   (frame_type),
        .command_code (command_code),
        .field_id     (field_id),
        .field_value  (field_value),
        .last_word    (last_word)
    );

`ifndef SYNTH
    a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result word pending while input side open");

    a_walk_on_footer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && rx_byte == FOOTER_BYTE))
        else $error("frame walk started without a footer byte");

    a_cells_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cells_reg <= CELL_W'(MAX_CELLS) || cells_reg == CELLS_RESET)
        else $error("expected cell count out of range");
`endif

endmodule

FILE: verif/tb.sv
// testbench for bms_reply_frame_receiver: drives reply byte streams, predicts result words
// depends on bmsr_pkg and the receiver rtl
`timescale 1ns / 1ps

module tb;
    import bmsr_pkg::*;

    localparam int NCELLS = 32;
    localparam int NSENS  = 4;
    localparam int DEPTH  = 72;

    typedef struct packed {
        logic [1:0]         ftype;
        logic [7:0]         cmd;
        logic [3:0]         fid;
        logic signed [16:0] value;
        logic               last;
    } word_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         frame_type;
    logic [7:0]         command_code;
    logic [3:0]         field_id;
    logic signed [16:0] field_value;
    logic               last_word;

    bms_reply_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_type   (frame_type),
        .command_code (command_code),
        .field_id     (field_id),
        .field_value  (field_value),
        .last_word    (last_word)
    );

    logic [7:0] byte_q[$];
    word_t      word_q[$];
    int         errors = 0;
    int         sent = 0;
    int         words_seen = 0;
    int         in_gap;
    int         out_gap;

    // predictor state
    phase_t     pm_phase;
    int         pm_count;
    logic [7:0] pm_store[DEPTH];
    int         pm_cells;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rd8(int i);
        return (i < DEPTH) ? pm_store[i] : 0;
    endfunction

    function automatic int rd16(int i);
        return (rd8(i) << 8) | rd8(i + 1);
    endfunction

    // cell frames in the queue are only meaningful with the count in effect when they
    // arrive; a mismatched length just yields an overlong or unfinished frame
    function automatic int pm_cells_hint();
        return $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 16;
    endfunction

    task automatic push_word(input logic [1:0] ft, input logic [7:0] cmd,
                             input int fid, input int v);
        word_t w;
        w.ftype = ft;
        w.cmd   = cmd;
        w.fid   = fid[3:0];
        w.value = v[16:0];
        w.last  = 1'b0;
        word_q.push_back(w);
    endtask

    task automatic close_frame(input int len);
        int         sum;
        int         calc;
        int         recv;
        int         cnt;
        int         sens;
        int         n0;
        int         lo, hi, lo_i, hi_i, mv, v, q;
        logic [7:0] cmd;
        sum = 0;
        n0 = word_q.size();
        cmd = 8'(rd8(1));
        for (int i = 2; i + 3 < len; i++) sum += rd8(i);
        calc = (32'h10000 - sum) & 16'hffff;
        recv = rd16(len - 3);
        if (calc != recv) begin
            push_word(FT_ERROR, cmd, 0, recv);
        end
        else if (cmd == CMD_STATUS) begin
            cnt = rd8(25);
            sens = rd8(26);
            if (cnt > NCELLS) cnt = NCELLS;
            pm_cells = cnt;
            push_word(FT_STATUS, cmd, 0, rd16(4));
            v = rd16(6);
            if (v >= 32768) v -= 65536;
            push_word(FT_STATUS, cmd, 1, v);
            push_word(FT_STATUS, cmd, 2, rd16(8));
            push_word(FT_STATUS, cmd, 3, rd16(10));
            push_word(FT_STATUS, cmd, 4, rd16(12));
            push_word(FT_STATUS, cmd, 5, rd16(20));
            push_word(FT_STATUS, cmd, 6, rd8(23));
            push_word(FT_STATUS, cmd, 7, cnt);
            push_word(FT_STATUS, cmd, 8, sens);
            if (sens > NSENS) sens = NSENS;
            for (int i = 0; i < sens; i++)
                push_word(FT_STATUS, cmd, 9 + i, rd16(27 + 2 * i));
        end
        else if (cmd == CMD_CELL) begin
            cnt = (len - 7) / 2;
            lo = 0; hi = 0; lo_i = 0; hi_i = 0;
            for (int i = 0; i < cnt; i++) begin
                mv = rd16(4 + 2 * i);
                if (i == 0 || mv < lo) begin lo = mv; lo_i = i + 1; end
                if (i == 0 || mv > hi) begin hi = mv; hi_i = i + 1; end
            end
            push_word(FT_CELL, cmd, 0, lo);
            push_word(FT_CELL, cmd, 1, lo_i);
            push_word(FT_CELL, cmd, 2, hi);
            push_word(FT_CELL, cmd, 3, hi_i);
            push_word(FT_CELL, cmd, 4, hi - lo);
        end
        else if (is_param(cmd)) begin
            v = rd16(4);
            if (is_temp(cmd)) begin
                q = v / 10;
                v = (q >= 274) ? q - 274 : q - 273;
            end
            push_word(FT_PARAM, cmd, 0, v);
        end
        if (word_q.size() > n0) word_q[word_q.size() - 1].last = 1'b1;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        int last_pos;
        last_pos = 0;
        case (pm_phase)
            P_PARAM:  last_pos = 8;
            P_STATUS: last_pos = 42;
            P_CELL:   last_pos = 2 * pm_cells + 6;
            default:  last_pos = 0;
        endcase
        case (pm_phase)
            P_IDLE:
            begin
                if (b == START_BYTE)
                begin
                    pm_store[0] = b;
                    pm_count = 1;
                    pm_phase = P_HEAD;
                end
            end
            P_HEAD:
            begin
                if (b >= CMD_STATUS && b <= CMD_MAX)
                begin
                    pm_phase = (b == CMD_STATUS) ? P_STATUS :
                               (b == CMD_CELL) ? P_CELL : P_PARAM;
                    pm_store[pm_count] = b;
                    pm_count++;
                end
                else
                begin
                    pm_phase = P_IDLE;
                    pm_count = 0;
                end
            end
            default:
            begin
                if (pm_count > last_pos)
                begin
                    pm_phase = P_IDLE;
                    pm_count = 0;
                end
                else if (b == FOOTER_BYTE && pm_count == last_pos)
                begin
                    pm_store[pm_count] = b;
                    close_frame(pm_count + 1);
                    pm_phase = P_IDLE;
                    pm_count = 0;
                end
                else
                begin
                    if (pm_count < DEPTH) pm_store[pm_count] = b;
                    pm_count = (pm_count + 1) & 8'h7f;
                end
            end
        endcase
    endtask

    task automatic report(input string what, input word_t got, input word_t want);
        $display("mismatch %s: got %0d/%0h/%0d/%0d/%0d want %0d/%0h/%0d/%0d/%0d", what,
                 got.ftype, got.cmd, got.fid, got.value, got.last,
                 want.ftype, want.cmd, want.fid, want.value, want.last);
        errors++;
    endtask

    // build a frame with the given command and payload; good or bad checksum
    task automatic add_frame(input logic [7:0] cmd, input logic [7:0] pl[$], input bit bad);
        int sum;
        int ck;
        sum = 0;
        byte_q.push_back(START_BYTE);
        byte_q.push_back(cmd);
        // status byte and length byte
        byte_q.push_back(8'h00);
        byte_q.push_back(8'(pl.size()));
        sum = pl.size();
        foreach (pl[i])
        begin
            byte_q.push_back(pl[i]);
            sum += pl[i];
        end
        ck = (32'h10000 - sum) & 16'hffff;
        if (bad) ck ^= (1 << $urandom_range(0, 15));
        byte_q.push_back(ck[15:8]);
        byte_q.push_back(ck[7:0]);
        byte_q.push_back(FOOTER_BYTE);
    endtask

    task automatic status_frame(input int cells, input int sens, input bit bad, input int fill);
        logic [7:0] pl[$];
        for (int i = 0; i < 36; i++)
            pl.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hff : 8'($urandom));
        pl[21] = 8'(cells);
        pl[22] = 8'(sens);
        add_frame(CMD_STATUS, pl, bad);
    endtask

    task automatic cell_frame(input int cells, input bit bad, input int fill);
        logic [7:0] pl[$];
        for (int i = 0; i < 2 * cells; i++)
            pl.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hff :
                         fill == 2 ? 8'($urandom_range(12, 14)) : 8'($urandom));
        add_frame(CMD_CELL, pl, bad);
    endtask

    task automatic param_frame(input logic [7:0] cmd, input logic [15:0] v, input bit bad);
        logic [7:0] pl[$];
        pl.push_back(v[15:8]);
        pl.push_back(v[7:0]);
        add_frame(cmd, pl, bad);
    endtask

    function automatic logic [7:0] rand_param();
        logic [7:0] codes[11] = '{8'h19, 8'h1b, 8'h1d, 8'h1f, 8'h20, 8'h21,
                                  8'h23, 8'h25, 8'h27, 8'h28, 8'h29};
        return codes[$urandom_range(0, 10)];
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_byte(rx_byte);
                sent <= sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (byte_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= byte_q.pop_front();
                    in_gap   <= gap_len();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                word_t got;
                word_t want;
                got = '{frame_type, command_code, field_id, field_value, last_word};
                words_seen <= words_seen + 1;
                if (word_q.size() == 0)
                begin
                    want = '0;
                    report("unexpected word", got, want);
                end
                else
                begin
                    want = word_q.pop_front();
                    if (got !== want) report("field", got, want);
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                out_gap   <= gap_len();
            end
        end
    end

    initial
    begin
        int k;
        pm_phase = P_IDLE;
        pm_count = 0;
        pm_cells = 16;
        foreach (pm_store[i]) pm_store[i] = 8'h00;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: noise, bad command, each frame kind and edge values
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hff);
        byte_q.push_back(START_BYTE);
        byte_q.push_back(8'h02);
        byte_q.push_back(START_BYTE);
        byte_q.push_back(8'h2a);
        cell_frame(16, 0, 3);
        status_frame(0, 0, 0, 0);
        cell_frame(0, 0, 0);
        status_frame(255, 255, 0, 1);
        cell_frame(32, 0, 1);
        status_frame(5, 2, 1, 3);
        param_frame(8'h19, 16'd2731, 0);
        param_frame(8'h1f, 16'hffff, 0);
        param_frame(8'h1b, 16'd0, 0);
        param_frame(8'h29, 16'hffff, 0);
        param_frame(8'h05, 16'h1234, 0);
        param_frame(8'h20, 16'h0077, 1);
        // overlong parameter frame: footer missing
        byte_q.push_back(START_BYTE);
        byte_q.push_back(8'h20);
        repeat (9) byte_q.push_back(8'h11);
        byte_q.push_back(8'h22);

        // random part: mostly well formed frames
        k = 0;
        while (k < 4)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 20) status_frame($urandom_range(0, 8), $urandom_range(0, 6),
                                     $urandom_range(0, 9) == 0, 3);
            else if (r < 22) status_frame($urandom_range(0, 40), $urandom_range(0, 255),
                                          $urandom_range(0, 9) == 0, 3);
            else if (r < 45) cell_frame(pm_cells_hint(), $urandom_range(0, 9) == 0,
                                        $urandom_range(2, 3));
            else if (r < 80) param_frame($urandom_range(0, 3) == 0 ?
                                         8'($urandom_range(3, 41)) : rand_param(),
                                         16'($urandom), $urandom_range(0, 7) == 0);
            else if (r < 90)
            begin
                repeat ($urandom_range(1, 5)) byte_q.push_back(8'($urandom));
            end
            else
            begin
                // truncated frame followed by noise
                byte_q.push_back(START_BYTE);
                byte_q.push_back(8'($urandom_range(3, 41)));
                repeat ($urandom_range(0, 10)) byte_q.push_back(8'($urandom));
            end
            k++;
        end
        // a status frame fixes the cell count for the rest
        status_frame(3, 1, 0, 3);

        while (byte_q.size() > 0 || word_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0 && word_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/bmsr_pkg.sv
sv/bmsr_ram.sv
sv/bmsr_frame_walk.sv
sv/bms_reply_frame_receiver.sv
verif/tb.sv
